/* hw/rtl/qdd_pkg.sv */
// Shared types, constants and the substep table of the quadrature detent decoder.
`timescale 1ns / 1ps

package qdd_pkg;

  localparam int PosWidth    = 32;
  localparam int CountWidth  = 32;
  localparam int DetentWidth = 7;
  localparam int SumWidth    = 8;
  localparam int CfgIdxWidth = 1;
  localparam int CfgDataWidth = DetentWidth;

  localparam logic [DetentWidth-1:0] DetentReset = 7'd4;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DETENT = 1'b0,
    REG_INVERT = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    FUNC_SAMPLE = 1'b0,
    FUNC_LOAD   = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  localparam logic [1:0] BothLevels = 2'b11;

  typedef logic signed [1:0] substep_t;

  // indexed by {previous A, previous B, current A, current B}
  localparam substep_t SubstepTable [0:15] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  typedef struct packed {
    logic                       func;
    logic [1:0]                 levels;
    logic signed [PosWidth-1:0] load_position;
  } item_t;

  typedef struct packed {
    logic [1:0]                 last_levels;
    logic signed [SumWidth-1:0] substep_sum;
    logic                       primed;
    logic signed [PosWidth-1:0] position;
    logic [CountWidth-1:0]      invalid;
  } state_t;

  typedef struct packed {
    logic signed [1:0]          step_delta;
    logic [1:0]                 turn_direction;
    logic signed [PosWidth-1:0] count_position;
    logic [CountWidth-1:0]      invalid_jumps;
  } result_t;

  typedef struct packed {
    logic [DetentWidth-1:0] detent_transitions;
    logic                   invert_direction;
  } cfg_t;

endpackage

/* hw/rtl/qdd_if.sv */
// Request and result channel interfaces of the quadrature detent decoder.
`timescale 1ns / 1ps

interface qdd_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic                                level_a;
  logic                                level_b;
  logic signed [qdd_pkg::PosWidth-1:0] load_position;

  modport source (output valid, func, level_a, level_b, load_position, input ready);
  modport sink (input valid, func, level_a, level_b, load_position, output ready);
endinterface

interface qdd_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [1:0]                     step_delta;
  logic [1:0]                            turn_direction;
  logic signed [qdd_pkg::PosWidth-1:0]   count_position;
  logic [qdd_pkg::CountWidth-1:0]        invalid_jumps;

  modport source (output valid, step_delta, turn_direction, count_position, invalid_jumps,
                  input ready);
  modport sink (input valid, step_delta, turn_direction, count_position, invalid_jumps,
                output ready);
endinterface

/* hw/rtl/qdd_step.sv */
// Next-state and result logic for one request of the quadrature detent decoder.
`timescale 1ns / 1ps

module qdd_step (
  input  qdd_pkg::item_t   item,
  input  qdd_pkg::state_t  state,
  input  qdd_pkg::cfg_t    cfg,
  output qdd_pkg::state_t  state_next,
  output qdd_pkg::result_t result
);

  logic [3:0]                          idx;
  qdd_pkg::substep_t                   substep;
  logic                                jump;
  logic signed [qdd_pkg::SumWidth-1:0] sum;
  logic signed [qdd_pkg::SumWidth-1:0] thresh;
  logic                                hit;
  logic                                up;

  assign idx     = {state.last_levels, item.levels};
  assign substep = qdd_pkg::SubstepTable[idx];
  assign jump    = (state.last_levels ^ item.levels) == qdd_pkg::BothLevels;
  assign sum     = jump ? '0
                        : state.substep_sum + {{(qdd_pkg::SumWidth-2){substep[1]}}, substep};
  assign thresh  = (cfg.detent_transitions == '0)
                   ? qdd_pkg::SumWidth'(1)
                   : $signed({1'b0, cfg.detent_transitions});
  assign hit     = (sum >= thresh) || (sum <= -thresh);
  assign up      = (sum > 0) ^ cfg.invert_direction;

  always_comb begin
    state_next             = state;
    result.step_delta      = 2'sd0;
    result.turn_direction  = qdd_pkg::DIR_NONE;
    state_next.last_levels = item.levels;
    if (item.func == qdd_pkg::FUNC_LOAD) begin
      state_next.position    = item.load_position;
      state_next.substep_sum = '0;
      state_next.invalid     = '0;
      state_next.primed      = 1'b1;
    end else if (!state.primed) begin
      state_next.substep_sum = '0;
      state_next.invalid     = '0;
      state_next.primed      = 1'b1;
    end else begin
      state_next.invalid     = state.invalid + qdd_pkg::CountWidth'(jump);
      state_next.substep_sum = sum;
      if (hit) begin
        state_next.substep_sum = '0;
        if (up) begin
          state_next.position   = state.position + qdd_pkg::PosWidth'(1);
          result.step_delta     = 2'sd1;
          result.turn_direction = qdd_pkg::DIR_CW;
        end else begin
          state_next.position   = state.position - qdd_pkg::PosWidth'(1);
          result.step_delta     = -2'sd1;
          result.turn_direction = qdd_pkg::DIR_CCW;
        end
      end
    end
    result.count_position = state_next.position;
    result.invalid_jumps  = state_next.invalid;
  end

endmodule

/* hw/rtl/quadrature_detent_decoder.sv */
// Top level of the quadrature detent decoder: request register, state and result register.
//
// Usage:
//   cmd carries one request per accepted handshake: a sample of the A and B
//   levels (func 0) or a load of levels and position (func 1).
//   res returns exactly one result per request, in order: the detent step,
//   its direction, the position and the count of rejected two-bit jumps.
//   Configuration is written through cfg_we / cfg_index / cfg_data while no
//   request is in flight; index 0 is the detent threshold, index 1 the
//   direction inversion.
//   A request passes the request register and then the result register on its way
//   to result valid; one request is taken every cycle while res does not stall, as the
//   table lookup and threshold compare that close the state loop are combinational.
//   Reset (rst, synchronous) clears the state, empties both registers and
//   sets the threshold to four and inversion off; the first sample after
//   reset only primes the levels.
//   When res stalls, the result register holds and one further request is
//   parked in the request register; cmd.ready then drops until res moves.
`timescale 1ns / 1ps

module quadrature_detent_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [qdd_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [qdd_pkg::CfgDataWidth-1:0]     cfg_data,
  qdd_cmd_if.sink                              cmd,
  qdd_res_if.source                            res
);

  qdd_pkg::item_t   item;
  logic             item_valid;
  qdd_pkg::state_t  state;
  qdd_pkg::state_t  state_next;
  qdd_pkg::cfg_t    cfg;
  qdd_pkg::result_t result;
  qdd_pkg::result_t result_next;
  logic             res_valid;
  logic             advance;

  assign advance   = !res_valid || res.ready;
  assign cmd.ready = !item_valid || advance;

  qdd_step u_step (
    .item       (item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid             <= 1'b0;
      res_valid              <= 1'b0;
      state                  <= '0;
      cfg.detent_transitions <= qdd_pkg::DetentReset;
      cfg.invert_direction   <= 1'b0;
    end else begin
      if (cmd.ready) begin
        item_valid <= cmd.valid;
      end
      if (advance) begin
        res_valid <= item_valid;
        if (item_valid) begin
          state <= state_next;
        end
      end
      if (cfg_we) begin
        unique case (qdd_pkg::cfg_reg_t'(cfg_index))
          qdd_pkg::REG_DETENT: cfg.detent_transitions <= cfg_data;
          qdd_pkg::REG_INVERT: cfg.invert_direction   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.func          <= cmd.func;
      item.levels        <= {cmd.level_a, cmd.level_b};
      item.load_position <= cmd.load_position;
    end
    if (advance && item_valid) begin
      result <= result_next;
    end
  end

  assign res.valid          = res_valid;
  assign res.step_delta     = result.step_delta;
  assign res.turn_direction = result.turn_direction;
  assign res.count_position = result.count_position;
  assign res.invalid_jumps  = result.invalid_jumps;

endmodule
